/* rtl/core/lasu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lasu_pkg;

  // Accumulator width: 64 terms of 37 bits each fit in 44 bits.
  localparam int unsigned AccW = 44;

  typedef struct packed {
    logic signed [15:0] key;
    logic signed [15:0] value;
    logic signed [15:0] recept;
    logic signed [15:0] bonus;
    logic        [15:0] decay;
  } chan_t;

  typedef struct packed {
    logic load;
    logic shift_key;
    logic shift_val;
  } cell_ctl_t;

  typedef struct packed {
    logic valid;
    logic head_ok;
    logic first;
    logic last;
  } iss_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_LOAD  = 4'b0010,
    ST_RUN   = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] x);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = AccW'(32'sh7fffffff);
    lo = -AccW'(32'sh7fffffff) - AccW'(1);
    if (x > hi) begin
      return 32'sh7fffffff;
    end else if (x < lo) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

endpackage

`default_nettype wire

/* rtl/core/linear_attention_state_update.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   head, key, value, receptance, bonus,
//                                               decay, last_channel
// out      output     out_valid_o / out_stall_i out_head, out_channel, wkv_out,
//                                               last_result
//
// A beat that is not the last of a head vector is stored in the buffer ring.
// The last beat starts a pass over the head's HEAD_LEN x HEAD_LEN state:
// one entry per cycle, while the output is not stalled, through a single
// multiply-accumulate pipeline. One result is produced per state row, and
// the input reopens once the last result of the head has been taken.
// After reset the state memory is cleared one entry per cycle; the input
// stalls until every entry is cleared.
// A stalled output freezes the whole pipeline until the result is taken.
module linear_attention_state_update #(
  parameter int unsigned HEAD_COUNT = 32,
  parameter int unsigned HEAD_LEN = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [4:0]         head_i,
  input  wire  signed [15:0] key_i,
  input  wire  signed [15:0] value_i,
  input  wire  signed [15:0] receptance_i,
  input  wire  signed [15:0] bonus_i,
  input  wire  [15:0]        decay_i,
  input  wire                last_channel_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [4:0]         out_head_o,
  output logic [5:0]         out_channel_o,
  output logic signed [31:0] wkv_out_o,
  output logic               last_result_o
);

  localparam int unsigned Depth = HEAD_COUNT * HEAD_LEN * HEAD_LEN;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned CW    = $clog2(HEAD_LEN);

  lasu_pkg::state_e state_q, state_d;

  logic [AW-1:0] clr_q;
  logic [CW-1:0] lc_q;     // load position
  logic [CW-1:0] i_q, j_q; // state row and column being issued
  logic [CW-1:0] och_q;    // channel of the next result
  logic [AW-1:0] addr_q;
  logic [4:0]    head_q;
  logic          head_ok_q;

  logic accept, en, row_end, run;
  logic out_take;
  logic res_valid;
  logic signed [31:0] res_data;
  logic head_ok_in;

  lasu_pkg::chan_t load_data;
  lasu_pkg::chan_t cell_data [HEAD_LEN];
  lasu_pkg::iss_t  iss;

  assign run        = (state_q == lasu_pkg::ST_RUN);
  assign in_stall_o = (state_q != lasu_pkg::ST_LOAD);
  assign accept     = in_valid_i && !in_stall_o;
  // The pipeline only moves when a finished result has somewhere to go.
  assign en         = !(out_valid_o && out_stall_i);
  assign row_end    = (j_q == CW'(HEAD_LEN - 1));
  assign out_take   = out_valid_o && !out_stall_i;
  assign head_ok_in = (32'(head_i) < HEAD_COUNT);

  assign load_data = '{key: key_i, value: value_i, recept: receptance_i,
                       bonus: bonus_i, decay: decay_i};

  // Buffer ring: cell g receives from cell g+1; cell 0 feeds the pipeline.
  for (genvar g = 0; g < HEAD_LEN; g++) begin : g_cell
    lasu_pkg::cell_ctl_t ctl;
    assign ctl = '{load: accept && (lc_q == CW'(g)),
                   shift_key: run && en,
                   shift_val: run && en && row_end};
    lasu_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .load_data_i (load_data),
      .next_i      (cell_data[(g + 1) % HEAD_LEN]),
      .data_o      (cell_data[g])
    );
  end

  assign iss = '{valid: run, head_ok: head_ok_q, first: (j_q == '0), last: row_end};

  lasu_datapath #(
    .HEAD_COUNT (HEAD_COUNT),
    .HEAD_LEN   (HEAD_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .clr_en_i    (state_q == lasu_pkg::ST_CLEAR),
    .clr_addr_i  (clr_q),
    .iss_i       (iss),
    .rd_addr_i   (addr_q),
    .op_i        (cell_data[0]),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      lasu_pkg::ST_CLEAR: begin
        if (clr_q == AW'(Depth - 1)) state_d = lasu_pkg::ST_LOAD;
      end
      lasu_pkg::ST_LOAD: begin
        if (accept && last_channel_i) state_d = lasu_pkg::ST_RUN;
      end
      lasu_pkg::ST_RUN: begin
        if (en && row_end && i_q == CW'(HEAD_LEN - 1)) state_d = lasu_pkg::ST_DRAIN;
      end
      lasu_pkg::ST_DRAIN: begin
        if (out_take && last_result_o) state_d = lasu_pkg::ST_LOAD;
      end
      default: state_d = lasu_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lasu_pkg::ST_CLEAR;
      clr_q     <= '0;
      lc_q      <= '0;
      i_q       <= '0;
      j_q       <= '0;
      och_q     <= '0;
      addr_q    <= '0;
      head_q    <= '0;
      head_ok_q <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == lasu_pkg::ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        if (last_channel_i) begin
          lc_q      <= '0;
          head_q    <= head_i;
          head_ok_q <= head_ok_in;
          addr_q    <= head_ok_in ? AW'(head_i) * AW'(HEAD_LEN * HEAD_LEN) : '0;
          i_q       <= '0;
          j_q       <= '0;
        end else begin
          lc_q <= (lc_q == CW'(HEAD_LEN - 1)) ? '0 : lc_q + CW'(1);
        end
      end
      if (run && en) begin
        addr_q <= addr_q + AW'(1);
        if (row_end) begin
          j_q <= '0;
          i_q <= i_q + CW'(1);
        end else begin
          j_q <= j_q + CW'(1);
        end
      end
      if (res_valid) begin
        out_valid_o <= 1'b1;
        och_q <= (och_q == CW'(HEAD_LEN - 1)) ? '0 : och_q + CW'(1);
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_head_o    <= head_q;
      out_channel_o <= 6'(och_q);
      wkv_out_o     <= res_data;
      last_result_o <= (och_q == CW'(HEAD_LEN - 1));
    end
  end

endmodule

`default_nettype wire

/* rtl/core/lasu_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One channel position of the buffer ring. Key, receptance, bonus and decay
// rotate together; the value rotates on its own, once per state row.
module lasu_cell (
  input  wire                  clk_i,
  input  lasu_pkg::cell_ctl_t  ctl_i,
  input  lasu_pkg::chan_t      load_data_i,
  input  lasu_pkg::chan_t      next_i,
  output lasu_pkg::chan_t      data_o
);

  lasu_pkg::chan_t data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= load_data_i;
    end else begin
      if (ctl_i.shift_key) begin
        data_q.key    <= next_i.key;
        data_q.recept <= next_i.recept;
        data_q.bonus  <= next_i.bonus;
        data_q.decay  <= next_i.decay;
      end
      if (ctl_i.shift_val) begin
        data_q.value <= next_i.value;
      end
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

/* rtl/core/lasu_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

// State memory and the multiply-accumulate pipeline. One state entry enters
// per enabled cycle; the updated entry is written back three stages later.
module lasu_datapath #(
  parameter int unsigned HEAD_COUNT = 32,
  parameter int unsigned HEAD_LEN = 64,
  localparam int unsigned Depth = HEAD_COUNT * HEAD_LEN * HEAD_LEN,
  localparam int unsigned AW = $clog2(Depth)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  en_i,
  input  wire                  clr_en_i,
  input  wire  [AW-1:0]        clr_addr_i,
  input  lasu_pkg::iss_t       iss_i,
  input  wire  [AW-1:0]        rd_addr_i,
  input  lasu_pkg::chan_t      op_i,
  output logic                 res_valid_o,
  output logic signed [31:0]   res_data_o
);

  logic signed [31:0] mem [Depth];
  logic signed [31:0] rd_q;

  lasu_pkg::iss_t ctl1_q, ctl2_q, ctl3_q, ctl4_q, ctl5_q;
  lasu_pkg::chan_t op1_q;
  logic [AW-1:0] addr1_q, addr2_q, addr3_q;

  logic signed [31:0] kv2_q, s2_q;
  logic signed [15:0] r2_q, tf2_q;
  logic        [15:0] td2_q;

  logic signed [47:0] pbt3_q;
  logic signed [48:0] psd3_q;
  logic signed [31:0] kv3_q, s3_q;
  logic signed [15:0] r3_q;

  logic signed [32:0] x4_q;
  logic signed [15:0] r4_q;
  logic signed [48:0] prod5_q;

  logic signed [lasu_pkg::AccW-1:0] acc_q, acc_d;

  logic signed [31:0] s1;
  logic signed [27:0] bt;
  logic signed [32:0] x;
  logic signed [33:0] ns;
  logic signed [lasu_pkg::AccW-1:0] term;

  assign s1   = ctl1_q.head_ok ? rd_q : 32'sd0;
  assign bt   = pbt3_q[47:20];
  assign x    = 33'(bt) + 33'(s3_q);
  assign ns   = 34'($signed(psd3_q[48:16])) + 34'($signed(kv3_q[31:8]));
  assign term = lasu_pkg::AccW'($signed(prod5_q[48:12]));
  assign acc_d = (ctl5_q.first ? '0 : acc_q) + term;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_en_i) begin
      mem[clr_addr_i] <= '0;
    end else if (en_i && ctl3_q.valid && ctl3_q.head_ok) begin
      mem[addr3_q] <= lasu_pkg::sat32(lasu_pkg::AccW'(ns));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
      ctl5_q <= '0;
    end else if (en_i) begin
      ctl1_q <= iss_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= ctl3_q;
      ctl5_q <= ctl4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op1_q   <= op_i;
      addr1_q <= rd_addr_i;
      kv2_q   <= op1_q.key * op1_q.value;
      s2_q    <= s1;
      r2_q    <= op1_q.recept;
      tf2_q   <= op1_q.bonus;
      td2_q   <= op1_q.decay;
      addr2_q <= addr1_q;
      pbt3_q  <= kv2_q * tf2_q;
      psd3_q  <= s2_q * $signed({1'b0, td2_q});
      kv3_q   <= kv2_q;
      s3_q    <= s2_q;
      r3_q    <= r2_q;
      addr3_q <= addr2_q;
      x4_q    <= x;
      r4_q    <= r3_q;
      prod5_q <= r4_q * x4_q;
      if (ctl5_q.valid) begin
        acc_q <= acc_d;
      end
    end
  end

  assign res_valid_o = en_i && ctl5_q.valid && ctl5_q.last;
  assign res_data_o  = lasu_pkg::sat32(acc_d);

endmodule

`default_nettype wire

/* rtl/core/lasu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module lasu_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               in_valid_i,
  input wire               in_stall_o,
  input wire               last_channel_i,
  input wire               out_valid_o,
  input wire               out_stall_i,
  input wire [5:0]         out_channel_o,
  input wire signed [31:0] wkv_out_o,
  input wire               last_result_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(wkv_out_o) &&
    $stable(out_channel_o))
    else $error("stalled result beat changed");

  // No input is taken while results are pending.
  a_no_in_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // The last channel beat closes the input.
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_channel_i |=> in_stall_o)
    else $error("input open after last channel beat");

  // The input stays closed after a taken result that is not the last.
  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_result_o |=> in_stall_o)
    else $error("input reopened before last result");

endmodule

bind linear_attention_state_update lasu_checker u_lasu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .last_channel_i (last_channel_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_channel_o  (out_channel_o),
  .wkv_out_o      (wkv_out_o),
  .last_result_o  (last_result_o)
);

`default_nettype wire

/* verif/tb_linear_attention_state_update.sv */
`timescale 1ns / 1ps

module tb_linear_attention_state_update;

  localparam int unsigned HeadCount = 32;
  localparam int unsigned HeadLen = 64;
  localparam longint unsigned CycleLimit = 5_000_000;

  typedef struct {
    logic [4:0]         head;
    logic [5:0]         channel;
    logic signed [31:0] wkv;
    logic               last;
  } wkv_result_t;

  // One directed row sends reps identical beats; only the final one carries last, if the row sets it.
  typedef struct {
    logic [4:0]         head;
    logic signed [15:0] key;
    logic signed [15:0] value;
    logic signed [15:0] recept;
    logic signed [15:0] bonus;
    logic [15:0]        decay;
    logic               last;
    int                 reps;
    bit                 known;
    logic signed [31:0] known_wkv;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [4:0]         head;
  logic signed [15:0] key;
  logic signed [15:0] value;
  logic signed [15:0] receptance;
  logic signed [15:0] bonus;
  logic [15:0]        decay;
  logic               last_channel;
  logic               out_valid;
  logic               out_stall;
  logic [4:0]         out_head;
  logic [5:0]         out_channel;
  logic signed [31:0] wkv_out;
  logic               last_result;

  linear_attention_state_update #(
    .HEAD_COUNT(HeadCount),
    .HEAD_LEN(HeadLen)
  ) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .head_i        (head),
    .key_i         (key),
    .value_i       (value),
    .receptance_i  (receptance),
    .bonus_i       (bonus),
    .decay_i       (decay),
    .last_channel_i(last_channel),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .out_head_o    (out_head),
    .out_channel_o (out_channel),
    .wkv_out_o     (wkv_out),
    .last_result_o (last_result)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Model state: the per-head state matrices and the channel buffer.
  logic signed [31:0] wkv_state [HeadCount*HeadLen*HeadLen];
  lasu_pkg::chan_t    chan_buf [HeadLen];
  int unsigned        fill_pos;
  wkv_result_t        wkv_expected [$];

  int          idle_pct;
  int          stall_pct;
  int          errors;
  int          beats_sent;
  int          results_seen;
  int          vectors_sent;
  longint unsigned cycles;

  function automatic logic signed [31:0] sat_q15(input longint x);
    if (x > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // Loads one channel beat; the last beat of a vector runs the head update and
  // queues one expected result per channel.
  function automatic void absorb_channel(input logic [4:0] hd, input lasu_pkg::chan_t c,
                                         input logic lst);
    longint kv, bt, s, acc, ns;
    int idx;
    bit head_ok;
    wkv_result_t r;
    chan_buf[fill_pos] = c;
    if (!lst) begin
      fill_pos = (fill_pos + 1) % HeadLen;
      return;
    end
    fill_pos = 0;
    vectors_sent++;
    head_ok = hd < HeadCount;
    for (int i = 0; i < HeadLen; i++) begin
      acc = 0;
      for (int j = 0; j < HeadLen; j++) begin
        idx = (int'(hd) * HeadLen + i) * HeadLen + j;
        kv = longint'(chan_buf[j].key) * longint'(chan_buf[i].value);
        s = head_ok ? longint'(wkv_state[idx]) : 0;
        bt = (kv * longint'(chan_buf[j].bonus)) >>> 20;
        acc += (longint'(chan_buf[j].recept) * (bt + s)) >>> 12;
        if (head_ok) begin
          ns = ((s * longint'({48'b0, chan_buf[j].decay})) >>> 16) + (kv >>> 8);
          wkv_state[idx] = sat_q15(ns);
        end
      end
      r.head = hd;
      r.channel = i[5:0];
      r.wkv = sat_q15(acc);
      r.last = (i == HeadLen - 1);
      wkv_expected.insert(wkv_expected.size(), r);
    end
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_beat(input logic [4:0] hd, input lasu_pkg::chan_t c, input logic lst);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    head         <= hd;
    key          <= c.key;
    value        <= c.value;
    receptance   <= c.recept;
    bonus        <= c.bonus;
    decay        <= c.decay;
    last_channel <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    absorb_channel(hd, c, lst);
    beats_sent++;
  endtask

  task automatic send_random_vector();
    lasu_pkg::chan_t c;
    logic [4:0] hd;
    int len;
    int kind;
    bit closes;
    kind = $urandom_range(0, 99);
    closes = 1'b1;
    if (kind < 60) begin
      len = $urandom_range(4, 20);
    end else if (kind < 85) begin
      len = $urandom_range(1, 8);
    end else begin
      // Left open; the next vector continues from the current load position.
      len = $urandom_range(1, 6);
      closes = 1'b0;
    end
    hd = 5'($urandom);
    for (int n = 0; n < len; n++) begin
      c.key = pick16();
      c.value = pick16();
      c.recept = pick16();
      c.bonus = pick16();
      c.decay = ($urandom_range(0, 3) == 0) ? pick16() : 16'($urandom);
      send_beat(($urandom_range(0, 3) == 0) ? 5'($urandom) : hd, c,
                closes && (n == len - 1));
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wkv_expected.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Result checker: every accepted beat is compared with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (wkv_expected.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) begin
          $display("Unexpected result: head %0d channel %0d wkv %0d",
                   out_head, out_channel, wkv_out);
        end
      end else begin
        if (out_head !== wkv_expected[0].head || out_channel !== wkv_expected[0].channel ||
            wkv_out !== wkv_expected[0].wkv || last_result !== wkv_expected[0].last) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("Mismatch: expected head %0d ch %0d wkv %0d last %0b, got %0d %0d %0d %0b",
                     wkv_expected[0].head, wkv_expected[0].channel, wkv_expected[0].wkv,
                     wkv_expected[0].last, out_head, out_channel, wkv_out, last_result);
          end
        end
        void'(wkv_expected.pop_front());
      end
    end
  end

  // Watchdog on total run length, including the state clear after reset.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout with %0d results outstanding", wkv_expected.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [8];
    lasu_pkg::chan_t c;
    int phase_idle[4];
    int phase_stall[4];
    int phase_start;
    in_valid     = 1'b0;
    head         = '0;
    key          = '0;
    value        = '0;
    receptance   = '0;
    bonus        = '0;
    decay        = '0;
    last_channel = 1'b0;
    out_stall    = 1'b0;
    rst_n        = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    errors       = 0;
    beats_sent   = 0;
    results_seen = 0;
    vectors_sent = 0;
    cycles       = 0;
    fill_pos     = 0;
    foreach (wkv_state[n]) wkv_state[n] = '0;

    // A vector of zeros that runs two beats past the buffer first, so every
    // buffer entry is written and the load position wraps; with a cleared
    // state every result is zero.
    dir_rows[0] = '{5'd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1, 66, 1'b1, 32'sd0};
    // Extremes, including short vectors that reuse older buffer contents.
    dir_rows[1] = '{5'd31, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b0, 1,
                    1'b0, 32'sd0};
    dir_rows[2] = '{5'd31, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'h0000, 1'b0, 1,
                    1'b0, 32'sd0};
    dir_rows[3] = '{5'd31, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'hffff, 1'b1, 1,
                    1'b0, 32'sd0};
    dir_rows[4] = '{5'd31, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'hffff, 1'b1, 1,
                    1'b0, 32'sd0};
    dir_rows[5] = '{5'd31, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'hffff, 1'b1, 4,
                    1'b0, 32'sd0};
    dir_rows[6] = '{5'd17, 16'sh1000, 16'shf000, 16'sh1000, 16'sh1000, 16'h8000, 1'b1, 2,
                    1'b0, 32'sd0};
    dir_rows[7] = '{5'd0, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh0000, 16'h0001, 1'b1, 3,
                    1'b0, 32'sd0};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) begin
      c.key = dir_rows[r].key;
      c.value = dir_rows[r].value;
      c.recept = dir_rows[r].recept;
      c.bonus = dir_rows[r].bonus;
      c.decay = dir_rows[r].decay;
      for (int n = 0; n < dir_rows[r].reps; n++) begin
        phase_start = wkv_expected.size();
        send_beat(dir_rows[r].head, c, dir_rows[r].last && (n == dir_rows[r].reps - 1));
        if (dir_rows[r].known) begin
          for (int q = phase_start; q < wkv_expected.size(); q++) begin
            wkv_expected[q].wkv = dir_rows[r].known_wkv;
          end
        end
      end
    end
    drain_results();

    // Random phases; the sender waits for every result before changing rates.
    phase_idle  = '{0, 63, 0, 37};
    phase_stall = '{0, 0, 63, 37};
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      phase_start = beats_sent;
      while (beats_sent - phase_start < 18) send_random_vector();
      // Close any vector that the random vectors left open.
      c = '0;
      send_beat(5'($urandom), c, 1'b1);
      drain_results();
    end

    idle_pct = 0;
    stall_pct = 0;
    repeat (HeadLen * HeadLen + 20) @(posedge clk);

    $display("Sent %0d channel beats in %0d head vectors over four handshake phases,",
             beats_sent, vectors_sent);
    $display("checked %0d results including saturation, short and wrapped vectors.",
             results_seen);
    if (errors == 0 && wkv_expected.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/lasu_pkg.sv
rtl/core/lasu_cell.sv
rtl/core/lasu_datapath.sv
rtl/core/linear_attention_state_update.sv
rtl/core/lasu_checker.sv
verif/tb_linear_attention_state_update.sv
